/* sv/trle_pkg.sv */
`timescale 1ns / 1ps
// trle_pkg: shared types and constants of the tile map run-length decoder
// used by trle_addr_gen and tilemap_rle_decoder; no dependencies

package trle_pkg;

    // field widths of the transaction payload and configuration
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned ADDR_W  = 15;
    localparam int unsigned ROWS_W  = 8;
    localparam int unsigned TABLE_W = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 15;

    // tile RAM depth follows the address width
    localparam int unsigned TILE_RAM_WORDS = 1 << ADDR_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_COUNT = 2'd2;

    // reset values of the configuration registers
    localparam logic [ADDR_W-1:0]  RST_BASE_ADDR   = 15'd0;
    localparam logic [ROWS_W-1:0]  RST_ROW_COUNT   = 8'd32;
    localparam logic [TABLE_W-1:0] RST_TABLE_COUNT = 3'd4;

    // commands from the parser to the address sequencer
    typedef struct packed {
        logic take;   // an input transaction was accepted
        logic emit;   // one tile write leaves this cycle
    } t_addr_cmd;

    // status of the write that leaves this cycle
    typedef struct packed {
        logic row_end;  // write is the last column of its row
        logic done;     // write is the last of the whole image
    } t_addr_status;

endpackage

/* sv/trle_addr_gen.sv */
`timescale 1ns / 1ps
// trle_addr_gen: tile RAM address sequencer with one shared address adder
// tracks columns, rows and tables; depends on trle_pkg

module trle_addr_gen #(
    parameter int ROW_COLUMNS        = 64,
    parameter int TABLE_STRIDE_WORDS = 2048,
    localparam int AW = trle_pkg::ADDR_W
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  trle_pkg::t_addr_cmd             i_cmd,
    input  logic [trle_pkg::ADDR_W-1:0]     i_base_addr,
    input  logic [trle_pkg::ROWS_W-1:0]     i_row_count,
    input  logic [trle_pkg::TABLE_W-1:0]    i_table_count,
    output logic [AW-1:0]                   o_address,
    output trle_pkg::t_addr_status          o_status
);

    // tile RAM depth is a power of two, so address wrap is the natural carry-out
    localparam int CW         = $clog2(ROW_COLUMNS + 1);
    localparam int STRIDE_MOD = TABLE_STRIDE_WORDS % trle_pkg::TILE_RAM_WORDS;
    localparam int ROW_BACK   = (2 * ROW_COLUMNS) % trle_pkg::TILE_RAM_WORDS;
    localparam int ROW_STEP   = (trle_pkg::TILE_RAM_WORDS + 1 - ROW_BACK)
                                % trle_pkg::TILE_RAM_WORDS;

    localparam logic [AW-1:0] STRIDE_V   = AW'(STRIDE_MOD);
    localparam logic [AW-1:0] ROW_STEP_V = AW'(ROW_STEP);
    localparam logic [AW-1:0] ONE_V      = AW'(1);
    localparam logic [CW-1:0] COLS_V     = CW'(ROW_COLUMNS);

    logic                             r_at_start, n_at_start;
    logic [AW-1:0]                    r_ptr, n_ptr;
    logic [trle_pkg::ROWS_W-1:0]      r_rows, n_rows;
    logic [CW-1:0]                    r_cols, n_cols;
    logic [trle_pkg::TABLE_W-1:0]     r_tab, n_tab;
    logic [AW-1:0]                    r_next_off, n_next_off;

    logic [AW-1:0]                    base_mod;
    logic [trle_pkg::ROWS_W-1:0]      rows_per_table;
    logic [trle_pkg::TABLE_W-1:0]     tables_per_image;
    logic [AW-1:0]                    ptr_cur;
    logic [trle_pkg::ROWS_W-1:0]      rows_cur;
    logic [trle_pkg::TABLE_W-1:0]     tab_inc;
    logic                             row_end;
    logic                             tbl_end;
    logic                             img_done;
    logic                             tbl_switch;
    logic [AW-1:0]                    add_a, add_b, add_sum;

    // effective configuration and current position
    always_comb begin
        base_mod         = AW'(i_base_addr);
        rows_per_table   = (i_row_count == '0) ? trle_pkg::ROWS_W'(1) : i_row_count;
        tables_per_image = (i_table_count == '0) ? trle_pkg::TABLE_W'(1) : i_table_count;
        // at start the position follows the registers as they are written
        ptr_cur          = r_at_start ? base_mod : r_ptr;
        rows_cur         = r_at_start ? rows_per_table : r_rows;
        tab_inc          = r_tab + trle_pkg::TABLE_W'(1);
        row_end          = (r_cols == CW'(1));
        tbl_end          = row_end && (rows_cur <= trle_pkg::ROWS_W'(1));
        img_done         = tbl_end && (tab_inc >= tables_per_image);
        tbl_switch       = tbl_end && !img_done;
    end

    // shared address adder: next column, next row start or next table start
    always_comb begin
        add_a   = tbl_switch ? base_mod : ptr_cur;
        add_b   = tbl_switch ? r_next_off : (row_end ? ROW_STEP_V : ONE_V);
        add_sum = add_a + add_b;
    end

    // sequencer next state
    always_comb begin
        n_at_start = r_at_start;
        n_ptr      = ptr_cur;
        n_rows     = rows_cur;
        n_cols     = r_cols;
        n_tab      = r_tab;
        n_next_off = r_next_off;
        if (i_cmd.take) begin
            n_at_start = 1'b0;
        end
        if (i_cmd.emit) begin
            n_ptr  = add_sum;
            n_cols = row_end ? COLS_V : r_cols - CW'(1);
            if (row_end && !tbl_end) begin
                n_rows = rows_cur - trle_pkg::ROWS_W'(1);
            end
            if (tbl_switch) begin
                n_tab      = tab_inc;
                n_rows     = rows_per_table;
                n_next_off = r_next_off + STRIDE_V;
            end
            if (img_done) begin
                n_at_start = 1'b1;
                n_tab      = '0;
                n_next_off = STRIDE_V;
                n_ptr      = base_mod;
                n_rows     = rows_per_table;
            end
        end
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
            r_cols     <= COLS_V;
            r_tab      <= '0;
            r_next_off <= STRIDE_V;
        end else begin
            r_at_start <= n_at_start;
            r_cols     <= n_cols;
            r_tab      <= n_tab;
            r_next_off <= n_next_off;
        end
        r_ptr  <= n_ptr;
        r_rows <= n_rows;
    end

    assign o_address       = ptr_cur;
    assign o_status.row_end = row_end;
    assign o_status.done    = img_done;

    // end of image brings the sequencer back to its start state
    a_done_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && img_done) |=> (r_at_start && r_tab == '0))
        else $error("image end did not return to start");

    // the column counter stays within one row
    a_cols_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cols != '0) && (r_cols <= COLS_V))
        else $error("column counter out of range");

    // a table always has at least one row left
    a_rows_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rows_cur != '0)
        else $error("row counter reached zero");

endmodule

/* sv/tilemap_rle_decoder.sv */
`timescale 1ns / 1ps
// tilemap_rle_decoder: top level, stream parser and output register
// depends on trle_pkg and trle_addr_gen
//
// Usage:
//   Input channel (i_valid / o_stall, i_compressed_word) takes one compressed word
//   per transaction. Output channel (o_valid / i_stall) gives one tile RAM write per
//   transaction: o_write_address, o_write_data, o_last_of_run, o_image_done.
//   A nonzero word gives one write, shown in the cycle after it is taken; plain
//   words flow at one per cycle while the receiver does not stall. An escape word
//   and the value word after it give no write. The count word starts a run: its
//   writes leave at one per cycle while the receiver does not stall, and the input
//   channel stalls until the last one has been registered. A run holds one write
//   more than its count word and ends early at a row's end, as the sequencer reports.
//   Configuration (i_cfg_wr_en, i_cfg_index, i_cfg_data) must be written only while
//   idle; the decoder does not enforce this. Reset (synchronous, active low) restores
//   the default registers and the start state, with no write pending. When the
//   receiver raises i_stall the held write stays on the outputs and no new write is made.

module tilemap_rle_decoder #(
    parameter int ROW_COLUMNS        = 64,
    parameter int TABLE_STRIDE_WORDS = 2048
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_wr_en,
    input  logic [trle_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [trle_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // compressed word input
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [trle_pkg::WORD_W-1:0]         i_compressed_word,
    // tile RAM write output
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [trle_pkg::ADDR_W-1:0]         o_write_address,
    output logic [trle_pkg::WORD_W-1:0]         o_write_data,
    output logic                                o_last_of_run,
    output logic                                o_image_done
);

    localparam int AW = trle_pkg::ADDR_W;

    typedef enum logic [1:0] {
        S_PLAIN,
        S_VALUE,
        S_COUNT,
        S_RUN
    } t_state;

    t_state                               r_state, n_state;
    logic [trle_pkg::WORD_W-1:0]          r_run_value, n_run_value;
    logic [trle_pkg::WORD_W-1:0]          r_remaining, n_remaining;

    logic [trle_pkg::ADDR_W-1:0]          r_base_addr;
    logic [trle_pkg::ROWS_W-1:0]          r_row_count;
    logic [trle_pkg::TABLE_W-1:0]         r_table_count;

    logic                                 r_out_valid;
    logic [trle_pkg::ADDR_W-1:0]          r_out_addr;
    logic [trle_pkg::WORD_W-1:0]          r_out_data;
    logic                                 r_out_last;
    logic                                 r_out_done;

    logic                                 out_free;
    logic                                 take;
    logic                                 emit;
    logic [trle_pkg::WORD_W-1:0]          emit_data;
    logic                                 emit_last;
    trle_pkg::t_addr_cmd                  addr_cmd;
    trle_pkg::t_addr_status               addr_status;
    logic [AW-1:0]                        addr_cur;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_addr   <= trle_pkg::RST_BASE_ADDR;
            r_row_count   <= trle_pkg::RST_ROW_COUNT;
            r_table_count <= trle_pkg::RST_TABLE_COUNT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                trle_pkg::REG_BASE_ADDR:   r_base_addr   <= i_cfg_data;
                trle_pkg::REG_ROW_COUNT:   r_row_count   <= i_cfg_data[trle_pkg::ROWS_W-1:0];
                trle_pkg::REG_TABLE_COUNT: r_table_count <= i_cfg_data[trle_pkg::TABLE_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake: input waits during a run or while a plain write cannot leave
    always_comb begin
        out_free = !r_out_valid || !i_stall;
        o_stall  = (r_state == S_RUN) || ((r_state == S_PLAIN) && !out_free);
        take     = i_valid && !o_stall;
    end

    // parser and run sequencer
    always_comb begin
        n_state     = r_state;
        n_run_value = r_run_value;
        n_remaining = r_remaining;
        emit        = 1'b0;
        emit_data   = i_compressed_word;
        emit_last   = 1'b1;
        unique case (r_state)
            S_PLAIN: begin
                if (take) begin
                    if (i_compressed_word == '0) begin
                        n_state = S_VALUE;
                    end else begin
                        emit = 1'b1;
                    end
                end
            end
            S_VALUE: begin
                if (take) begin
                    n_run_value = i_compressed_word;
                    n_state     = S_COUNT;
                end
            end
            S_COUNT: begin
                if (take) begin
                    n_remaining = i_compressed_word;
                    n_state     = S_RUN;
                end
            end
            S_RUN: begin
                emit_data = r_run_value;
                emit_last = (r_remaining == '0) || addr_status.row_end;
                if (out_free) begin
                    emit = 1'b1;
                    if (emit_last) begin
                        n_state = S_PLAIN;
                    end else begin
                        n_remaining = r_remaining - trle_pkg::WORD_W'(1);
                    end
                end
            end
            default: n_state = S_PLAIN;
        endcase
    end

    always_comb begin
        addr_cmd.take = take;
        addr_cmd.emit = emit;
    end

    trle_addr_gen #(
        .ROW_COLUMNS        (ROW_COLUMNS),
        .TABLE_STRIDE_WORDS (TABLE_STRIDE_WORDS)
    ) u_addr_gen (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (addr_cmd),
        .i_base_addr    (r_base_addr),
        .i_row_count    (r_row_count),
        .i_table_count  (r_table_count),
        .o_address      (addr_cur),
        .o_status       (addr_status)
    );

    // state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_PLAIN;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        r_run_value <= n_run_value;
        r_remaining <= n_remaining;
        if (emit) begin
            r_out_addr <= trle_pkg::ADDR_W'(addr_cur);
            r_out_data <= emit_data;
            r_out_last <= emit_last;
            r_out_done <= addr_status.done;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_write_address = r_out_addr;
    assign o_write_data    = r_out_data;
    assign o_last_of_run   = r_out_last;
    assign o_image_done    = r_out_done;

    // a write never overwrites a held write the receiver has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free)
        else $error("write issued while output register is held");

    // the last write of an image also ends the run that caused it
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && addr_status.done) |-> emit_last)
        else $error("image end without end of run");

    // the last write of a run returns the parser to plain words
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && emit && emit_last) |=> (r_state == S_PLAIN))
        else $error("run did not end after its last write");

endmodule
